// ----- hdl/usb_data_packetizer_crc16_macros.svh -----
// Assertion macros for the packetizer checker.
`ifndef USB_DATA_PACKETIZER_CRC16_MACROS_SVH
`define USB_DATA_PACKETIZER_CRC16_MACROS_SVH

// Same-cycle implication, switched off while reset is high.
`define UDPC_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("udpc: same-cycle check failed");

// Next-cycle implication, switched off while reset is high.
`define UDPC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("udpc: next-cycle check failed");

// Next-cycle implication that also holds through reset.
`define UDPC_ASSERT_NEXT_ANY(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("udpc: reset check failed");

`endif

// ----- hdl/udpc_pkg.sv -----
// Shared constants, types and the CRC-16 byte update for the packetizer.
package udpc_pkg;

  localparam int MAX_PAYLOAD_DEF = 8;

  localparam logic [7:0]  SYNC_BYTE = 8'h80;
  localparam logic [15:0] CRC_INIT  = 16'hFFFF;
  localparam logic [15:0] CRC_POLY  = 16'hA001;

  localparam logic [7:0] PID_DATA0_RESET = 8'd195;
  localparam logic [7:0] PID_DATA1_RESET = 8'd75;

  // Configuration register indexes.
  localparam int         CFG_INDEX_W   = 8;
  localparam logic [7:0] REG_PID_DATA0 = 8'd0;
  localparam logic [7:0] REG_PID_DATA1 = 8'd1;

  // Packet descriptor passed from the gathering side to the emitting side.
  typedef struct packed {
    logic [15:0] crc;    // final, already inverted CRC of the payload
    logic        data1;  // packet goes out as DATA1
    logic        eom;    // CRC high byte closes the message
    logic        zlp;    // a zero-length packet follows
  } pkt_desc_t;

  // Reflected CRC-16 update over one byte, least significant bit first.
  function automatic logic [15:0] crc_feed(input logic [15:0] crc_in,
                                           input logic [7:0]  byte_in);
    logic [15:0] c;
    c = crc_in ^ {8'h00, byte_in};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ----- hdl/udpc_front.sv -----
// Front end: takes message bytes, stores them, runs the CRC and closes packets.
module udpc_front #(
  parameter int MAX_PAYLOAD = 8,
  parameter int CNT_W       = 4,
  parameter int IDX_W       = 3
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            data_byte,
  input  logic                  first_of_message,
  input  logic                  force_data1,
  input  logic                  last_of_message,
  input  logic                  q_full,
  input  logic                  q_wr_slot,
  output logic                  q_push,
  output udpc_pkg::pkt_desc_t   q_desc,
  output logic [CNT_W-1:0]      q_count,
  output logic                  mem_we,
  output logic [IDX_W:0]        mem_addr,
  output logic [7:0]            mem_wdata
);
  import udpc_pkg::*;

  logic [CNT_W-1:0] cnt;
  logic [15:0]      crc;
  logic             tog;

  logic             accept;
  logic [CNT_W-1:0] cnt_base;
  logic [CNT_W-1:0] cnt_new;
  logic [15:0]      crc_base;
  logic [15:0]      crc_new;
  logic             tog_base;
  logic             full;
  logic             close;

  // The bank being filled is free only while the queue has a slot.
  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // A message start drops an open packet and may force DATA1.
  always_comb begin
    cnt_base = first_of_message ? '0 : cnt;
    crc_base = first_of_message ? CRC_INIT : crc;
    tog_base = (first_of_message && force_data1) ? 1'b1 : tog;
    cnt_new  = cnt_base + CNT_W'(1);
    crc_new  = crc_feed(crc_base, data_byte);
    full     = (cnt_new == CNT_W'(MAX_PAYLOAD));
    close    = last_of_message || full;
  end

  // Store the byte in the bank that belongs to the queue's write slot.
  assign mem_we    = accept;
  assign mem_addr  = {q_wr_slot, cnt_base[IDX_W-1:0]};
  assign mem_wdata = data_byte;

  // Descriptor of the packet that this byte closes.
  assign q_push       = accept && close;
  assign q_count      = cnt_new;
  assign q_desc.crc   = ~crc_new;
  assign q_desc.data1 = tog_base;
  assign q_desc.eom   = last_of_message && !full;
  assign q_desc.zlp   = last_of_message && full;

  // Gathering state: byte count, running CRC and DATA0/DATA1 toggle.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      crc <= CRC_INIT;
      tog <= 1'b0;
    end else if (accept) begin
      if (close) begin
        cnt <= '0;
        crc <= CRC_INIT;
        // A trailing zero-length packet takes the second toggle.
        tog <= q_desc.zlp ? tog_base : ~tog_base;
      end else begin
        cnt <= cnt_new;
        crc <= crc_new;
        tog <= tog_base;
      end
    end
  end

endmodule

// ----- hdl/udpc_queue.sv -----
// Two-entry queue of packet descriptors; the slot number also names the payload bank.
module udpc_queue #(
  parameter int CNT_W = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  udpc_pkg::pkt_desc_t push_desc,
  input  logic [CNT_W-1:0]    push_count,
  input  logic                pop,
  output logic                full,
  output logic                empty,
  output logic                wr_slot,
  output logic                rd_slot,
  output udpc_pkg::pkt_desc_t head_desc,
  output logic [CNT_W-1:0]    head_count
);
  import udpc_pkg::*;

  pkt_desc_t        desc_q  [2];
  logic [CNT_W-1:0] count_q [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       fill;

  assign full       = (fill == 2'd2);
  assign empty      = (fill == 2'd0);
  assign wr_slot    = wr_ptr;
  assign rd_slot    = rd_ptr;
  assign head_desc  = desc_q[rd_ptr];
  assign head_count = count_q[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      desc_q[wr_ptr]  <= push_desc;
      count_q[wr_ptr] <= push_count;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ----- hdl/udpc_back.sv -----
// Back end: holds the payload banks and sends sync, PID, payload and CRC bytes.
module udpc_back #(
  parameter int CNT_W = 4,
  parameter int IDX_W = 3
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                mem_we,
  input  logic [IDX_W:0]      mem_addr,
  input  logic [7:0]          mem_wdata,
  input  logic                q_empty,
  input  logic                q_rd_slot,
  input  udpc_pkg::pkt_desc_t q_desc,
  input  logic [CNT_W-1:0]    q_count,
  output logic                q_pop,
  input  logic [7:0]          pid_data0_code,
  input  logic [7:0]          pid_data1_code,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          packet_byte,
  output logic                end_of_packet,
  output logic                end_of_message
);
  import udpc_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PID,
    ST_DATA,
    ST_CRCL,
    ST_CRCH,
    ST_ZSYNC,
    ST_ZPID,
    ST_ZCRCL,
    ST_ZCRCH
  } state_t;

  state_t           state;
  state_t           state_next;
  logic [CNT_W-1:0] idx;
  logic [CNT_W-1:0] idx_next;
  logic             load;
  logic [7:0]       byte_next;
  logic             eop_next;
  logic             eom_next;
  logic             slot_free;

  logic [7:0]       mem [2**(IDX_W+1)];
  logic [IDX_W:0]   rd_addr;
  logic [7:0]       rd_data;

  // Payload banks: one write from the front, one registered read here.
  assign rd_addr = {q_rd_slot, idx_next[IDX_W-1:0]};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    rd_data <= mem[rd_addr];
  end

  // The output register can take a byte when empty or being drained.
  assign slot_free = !out_valid || out_ready;

  // Byte sequencer for one descriptor.
  always_comb begin
    state_next = state;
    idx_next   = idx;
    load       = 1'b0;
    byte_next  = packet_byte;
    eop_next   = 1'b0;
    eom_next   = 1'b0;
    q_pop      = 1'b0;
    case (state)
      ST_IDLE: begin
        idx_next = '0;
        if (!q_empty && slot_free) begin
          load       = 1'b1;
          byte_next  = SYNC_BYTE;
          state_next = ST_PID;
        end
      end
      ST_PID: begin
        if (slot_free) begin
          load       = 1'b1;
          byte_next  = q_desc.data1 ? pid_data1_code : pid_data0_code;
          state_next = ST_DATA;
        end
      end
      ST_DATA: begin
        if (slot_free) begin
          load      = 1'b1;
          byte_next = rd_data;
          idx_next  = idx + CNT_W'(1);
          if (idx_next == q_count) begin
            state_next = ST_CRCL;
          end
        end
      end
      ST_CRCL: begin
        if (slot_free) begin
          load       = 1'b1;
          byte_next  = q_desc.crc[7:0];
          state_next = ST_CRCH;
        end
      end
      ST_CRCH: begin
        if (slot_free) begin
          load      = 1'b1;
          byte_next = q_desc.crc[15:8];
          eop_next  = 1'b1;
          eom_next  = q_desc.eom;
          // The descriptor stays at the head while a zero-length packet follows.
          q_pop      = !q_desc.zlp;
          state_next = q_desc.zlp ? ST_ZSYNC : ST_IDLE;
        end
      end
      ST_ZSYNC: begin
        if (slot_free) begin
          load       = 1'b1;
          byte_next  = SYNC_BYTE;
          state_next = ST_ZPID;
        end
      end
      ST_ZPID: begin
        if (slot_free) begin
          load       = 1'b1;
          byte_next  = q_desc.data1 ? pid_data0_code : pid_data1_code;
          state_next = ST_ZCRCL;
        end
      end
      ST_ZCRCL: begin
        if (slot_free) begin
          load       = 1'b1;
          byte_next  = 8'h00;
          state_next = ST_ZCRCH;
        end
      end
      ST_ZCRCH: begin
        if (slot_free) begin
          load       = 1'b1;
          byte_next  = 8'h00;
          eop_next   = 1'b1;
          eom_next   = 1'b1;
          q_pop      = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State, byte index and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    if (load) begin
      packet_byte    <= byte_next;
      end_of_packet  <= eop_next;
      end_of_message <= eom_next;
    end
  end

endmodule

// ----- hdl/usb_data_packetizer_crc16.sv -----
// A byte that closes a packet queues a descriptor; the sequencer then sends its sync byte.
// Input side takes one byte per cycle while one of the two payload banks is free.
// Output side sends one byte per cycle while the receiver is ready; a packet of n payload bytes
// is n + 4 bytes and a trailing zero-length packet 4 more, so the output sequencer sets the sustained rate.
// Reset (synchronous) empties the queue and output register, clears the count, CRC and
// toggle, and loads the PID registers with 0xC3 and 0x4B; no clearing pass is needed.
module usb_data_packetizer_crc16 #(
  parameter int MAX_PAYLOAD = udpc_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [7:0]                   data_byte,
  input  logic                         first_of_message,
  input  logic                         force_data1,
  input  logic                         last_of_message,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [7:0]                   packet_byte,
  output logic                         end_of_packet,
  output logic                         end_of_message,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [udpc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [7:0]                   cfg_data
);
  import udpc_pkg::*;

  localparam int CNT_W = $clog2(MAX_PAYLOAD + 1);
  localparam int IDX_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  logic [7:0]       pid_data0_code;
  logic [7:0]       pid_data1_code;

  logic             q_full;
  logic             q_empty;
  logic             q_wr_slot;
  logic             q_rd_slot;
  logic             q_push;
  logic             q_pop;
  pkt_desc_t        push_desc;
  pkt_desc_t        head_desc;
  logic [CNT_W-1:0] push_count;
  logic [CNT_W-1:0] head_count;

  logic             mem_we;
  logic [IDX_W:0]   mem_addr;
  logic [7:0]       mem_wdata;

  // PID registers; an unknown index is dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pid_data0_code <= PID_DATA0_RESET;
      pid_data1_code <= PID_DATA1_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_PID_DATA0) begin
        pid_data0_code <= cfg_data;
      end
      if (cfg_index == REG_PID_DATA1) begin
        pid_data1_code <= cfg_data;
      end
    end
  end

  udpc_front #(
    .MAX_PAYLOAD (MAX_PAYLOAD),
    .CNT_W       (CNT_W),
    .IDX_W       (IDX_W)
  ) u_front (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .data_byte        (data_byte),
    .first_of_message (first_of_message),
    .force_data1      (force_data1),
    .last_of_message  (last_of_message),
    .q_full           (q_full),
    .q_wr_slot        (q_wr_slot),
    .q_push           (q_push),
    .q_desc           (push_desc),
    .q_count          (push_count),
    .mem_we           (mem_we),
    .mem_addr         (mem_addr),
    .mem_wdata        (mem_wdata)
  );

  udpc_queue #(
    .CNT_W (CNT_W)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_desc  (push_desc),
    .push_count (push_count),
    .pop        (q_pop),
    .full       (q_full),
    .empty      (q_empty),
    .wr_slot    (q_wr_slot),
    .rd_slot    (q_rd_slot),
    .head_desc  (head_desc),
    .head_count (head_count)
  );

  udpc_back #(
    .CNT_W (CNT_W),
    .IDX_W (IDX_W)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .mem_we         (mem_we),
    .mem_addr       (mem_addr),
    .mem_wdata      (mem_wdata),
    .q_empty        (q_empty),
    .q_rd_slot      (q_rd_slot),
    .q_desc         (head_desc),
    .q_count        (head_count),
    .q_pop          (q_pop),
    .pid_data0_code (pid_data0_code),
    .pid_data1_code (pid_data1_code),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .packet_byte    (packet_byte),
    .end_of_packet  (end_of_packet),
    .end_of_message (end_of_message)
  );

endmodule

// ----- hdl/udpc_checker.sv -----
// Port-level checks on the packetizer output, bound to the top level.
`include "usb_data_packetizer_crc16_macros.svh"

module udpc_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] packet_byte,
  input logic       end_of_packet,
  input logic       end_of_message
);
  import udpc_pkg::*;

  // The last byte of a packet is taken by the receiver.
  logic eop_taken;
  assign eop_taken = out_valid && out_ready && end_of_packet;

  // A pending result request holds until taken.
  `UDPC_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid)

  // A pending result keeps its byte.
  `UDPC_ASSERT_NEXT(a_out_stable, clk, rst, out_valid && !out_ready, $stable(packet_byte))

  // The end of a message is always the end of a packet.
  `UDPC_ASSERT_SAME(a_eom_eop, clk, rst, out_valid && end_of_message, end_of_packet)

  // Whatever follows a packet's last byte opens with the sync byte.
  `UDPC_ASSERT_NEXT(a_sync_after_eop, clk, rst, eop_taken, !out_valid || packet_byte == SYNC_BYTE)

  // Reset empties the output register.
  `UDPC_ASSERT_NEXT_ANY(a_reset_empty, clk, rst, !out_valid)

endmodule

bind usb_data_packetizer_crc16 udpc_checker u_checker (.*);

// ----- tb/tb_top.sv -----
// Self-checking testbench for the USB data packetizer with CRC-16: directed rows, then random traffic.
`timescale 1ns / 1ps

module tb_top;
  import udpc_pkg::*;

  localparam int PAYLOAD_MAX   = MAX_PAYLOAD_DEF;
  localparam int SETTLE_CYCLES = 30;
  localparam int HOLD_CYCLES   = 150;
  localparam int STALL_LIMIT   = 4000;
  localparam int NO_PID        = -1;
  localparam int DIR_ROWS      = 24;

  // One byte on the packet side.
  typedef struct packed {
    logic [7:0] value;
    logic       eop;
    logic       eom;
  } tx_byte_t;

  // One directed request; pid holds a typed-in PID for the packet it closes.
  typedef struct {
    logic [7:0] value;
    logic       first;
    logic       force_d1;
    logic       last;
    int         pid;
  } dir_row_t;

  logic       clk              = 1'b0;
  logic       rst              = 1'b1;
  logic       in_valid         = 1'b0;
  logic       in_ready;
  logic [7:0] data_byte        = 8'h00;
  logic       first_of_message = 1'b0;
  logic       force_data1      = 1'b0;
  logic       last_of_message  = 1'b0;
  logic       out_valid;
  logic       out_ready        = 1'b0;
  logic [7:0] packet_byte;
  logic       end_of_packet;
  logic       end_of_message;
  logic       cfg_valid        = 1'b0;
  logic       cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [7:0] cfg_data         = 8'h00;

  // Predicted packet stream and the packetizer state behind it.
  tx_byte_t   tx_bytes_due[$];
  logic [7:0] pid_code0 = PID_DATA0_RESET;
  logic [7:0] pid_code1 = PID_DATA1_RESET;
  logic [7:0] gathered[PAYLOAD_MAX];
  int         gathered_n = 0;
  logic [15:0] crc_acc = CRC_INIT;
  logic       next_data1 = 1'b0;

  int fail_count     = 0;
  int items_sent     = 0;
  int bytes_checked  = 0;
  int packets_seen   = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_trigger   = 0;
  int hold_seen      = 0;
  int hold_left      = 0;
  int quiet_cycles   = 0;

  dir_row_t dir_rows[DIR_ROWS] = '{
    // Single-byte messages right after reset, then a forced DATA1 start.
    '{8'h00, 1'b1, 1'b0, 1'b1, PID_DATA0_RESET},
    '{8'hFF, 1'b1, 1'b0, 1'b1, PID_DATA1_RESET},
    '{8'hA5, 1'b1, 1'b1, 1'b1, PID_DATA1_RESET},
    // Exactly eight bytes: full last packet, then a zero-length packet.
    '{8'h01, 1'b1, 1'b0, 1'b0, NO_PID},
    '{8'h02, 1'b0, 1'b0, 1'b0, NO_PID},
    '{8'h04, 1'b0, 1'b0, 1'b0, NO_PID},
    '{8'h08, 1'b0, 1'b0, 1'b0, NO_PID},
    '{8'h10, 1'b0, 1'b0, 1'b0, NO_PID},
    '{8'h20, 1'b0, 1'b0, 1'b0, NO_PID},
    '{8'h40, 1'b0, 1'b0, 1'b0, NO_PID},
    '{8'h80, 1'b0, 1'b0, 1'b1, PID_DATA0_RESET},
    // Ten bytes: the packet fills mid-message, a stray force is ignored.
    '{8'h7E, 1'b1, 1'b1, 1'b0, NO_PID},
    '{8'h81, 1'b0, 1'b0, 1'b0, NO_PID},
    '{8'h3C, 1'b0, 1'b0, 1'b0, NO_PID},
    '{8'hC3, 1'b0, 1'b0, 1'b0, NO_PID},
    '{8'h5A, 1'b0, 1'b0, 1'b0, NO_PID},
    '{8'hA5, 1'b0, 1'b0, 1'b0, NO_PID},
    '{8'h0F, 1'b0, 1'b0, 1'b0, NO_PID},
    '{8'hF0, 1'b0, 1'b0, 1'b0, PID_DATA1_RESET},
    '{8'h11, 1'b0, 1'b1, 1'b0, NO_PID},
    '{8'hEE, 1'b0, 1'b0, 1'b1, PID_DATA0_RESET},
    // A new message starts while a packet is open: the open byte is dropped.
    '{8'h55, 1'b1, 1'b0, 1'b0, NO_PID},
    '{8'h3C, 1'b1, 1'b0, 1'b0, NO_PID},
    '{8'h99, 1'b0, 1'b0, 1'b1, PID_DATA1_RESET}
  };

  usb_data_packetizer_crc16 u_dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .data_byte        (data_byte),
    .first_of_message (first_of_message),
    .force_data1      (force_data1),
    .last_of_message  (last_of_message),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .packet_byte      (packet_byte),
    .end_of_packet    (end_of_packet),
    .end_of_message   (end_of_message),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  // 50 MHz clock.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Reflected CRC-16 update, one message bit at a time, LSB first.
  function automatic logic [15:0] crc16_usb_step(logic [15:0] acc, logic [7:0] b);
    logic fb;
    for (int k = 0; k < 8; k++) begin
      fb  = acc[0] ^ b[k];
      acc = acc >> 1;
      if (fb) acc = acc ^ CRC_POLY;
    end
    return acc;
  endfunction

  function automatic void emit(logic [7:0] v, logic eop, logic eom);
    tx_bytes_due.push_back('{value: v, eop: eop, eom: eom});
  endfunction

  // PID for the next packet; the DATA0/DATA1 toggle flips on every packet.
  function automatic logic [7:0] take_pid();
    logic [7:0] pid;
    pid = next_data1 ? pid_code1 : pid_code0;
    next_data1 = ~next_data1;
    return pid;
  endfunction

  // Gathers one message byte and queues every packet byte it releases.
  function automatic void packetize(logic [7:0] b, logic first, logic force_d1, logic last);
    logic        full;
    logic [15:0] crc_out;
    if (first) begin
      gathered_n = 0;
      crc_acc    = CRC_INIT;
      if (force_d1) next_data1 = 1'b1;
    end
    if (gathered_n >= PAYLOAD_MAX) gathered_n = 0;
    gathered[gathered_n] = b;
    crc_acc = crc16_usb_step(crc_acc, b);
    gathered_n++;
    if (gathered_n < PAYLOAD_MAX && !last) return;

    full = (gathered_n == PAYLOAD_MAX);
    emit(SYNC_BYTE, 1'b0, 1'b0);
    emit(take_pid(), 1'b0, 1'b0);
    for (int i = 0; i < gathered_n; i++) emit(gathered[i], 1'b0, 1'b0);
    crc_out = ~crc_acc;
    emit(crc_out[7:0], 1'b0, 1'b0);
    emit(crc_out[15:8], 1'b1, last && !full);
    gathered_n = 0;
    crc_acc    = CRC_INIT;

    // A message that ends on a full packet is closed by a zero-length packet.
    if (last && full) begin
      crc_out = ~CRC_INIT;
      emit(SYNC_BYTE, 1'b0, 1'b0);
      emit(take_pid(), 1'b0, 1'b0);
      emit(crc_out[7:0], 1'b0, 1'b0);
      emit(crc_out[15:8], 1'b1, 1'b1);
    end
  endfunction

  // Offers one byte request, with a random idle gap first, and predicts it on acceptance.
  task automatic offer_byte(logic [7:0] b, logic first, logic force_d1, logic last, int pid);
    int base;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    data_byte        <= b;
    first_of_message <= first;
    force_data1      <= force_d1;
    last_of_message  <= last;
    do @(posedge clk); while (!in_ready);
    base = tx_bytes_due.size();
    packetize(b, first, force_d1, last);
    if (pid != NO_PID && tx_bytes_due.size() > base + 1)
      tx_bytes_due[base + 1].value = pid[7:0];
    items_sent++;
  endtask

  // Stops offering and waits until every predicted byte has come out.
  task automatic pause_until_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (tx_bytes_due.size() != 0);
  endtask

  task automatic settle();
    pause_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes both PID registers, then one index that the block must ignore.
  task automatic program_regs(logic [7:0] d0, logic [7:0] d1,
                              logic [CFG_INDEX_W-1:0] stray_idx, logic [7:0] stray_val);
    logic [CFG_INDEX_W-1:0] idx[3];
    logic [7:0]             val[3];
    idx = '{REG_PID_DATA0, REG_PID_DATA1, stray_idx};
    val = '{d0, d1, stray_val};
    for (int k = 0; k < 3; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[k];
      cfg_data  <= val[k];
      do @(posedge clk); while (!cfg_ready);
      if (idx[k] == REG_PID_DATA0) pid_code0 = val[k];
      else if (idx[k] == REG_PID_DATA1) pid_code1 = val[k];
    end
    cfg_valid <= 1'b0;
  endtask

  // Sends one message; headless skips the start mark, cut leaves it unterminated.
  task automatic send_message(int len, logic force_d1, bit headless, bit cut);
    logic first;
    for (int i = 0; i < len; i++) begin
      first = (i == 0) && !headless;
      offer_byte(8'($urandom_range(255)), first,
                 first ? force_d1 : 1'($urandom_range(1)),
                 (i == len - 1) && !cut, NO_PID);
    end
  endtask

  // Random messages, mostly well formed, with some cut short or missing their start.
  task automatic run_traffic(int n_items, bit pause_mid);
    int start;
    int kind;
    int pick;
    int len;
    bit open;
    bit paused;
    start  = items_sent;
    open   = 0;
    paused = 0;
    while (items_sent - start < n_items) begin
      if (pause_mid && !paused && items_sent - start >= n_items / 2) begin
        pause_until_drained();
        paused = 1;
      end
      pick = $urandom_range(99);
      if (pick < 45) len = $urandom_range(1, PAYLOAD_MAX - 1);
      else if (pick < 60) len = PAYLOAD_MAX;
      else if (pick < 75) len = $urandom_range(PAYLOAD_MAX + 1, 2 * PAYLOAD_MAX - 1);
      else if (pick < 85) len = 2 * PAYLOAD_MAX;
      else len = $urandom_range(2 * PAYLOAD_MAX + 1, 3 * PAYLOAD_MAX);
      kind = $urandom_range(99);
      if (kind < 82) begin
        send_message(len, 1'($urandom_range(1)), 0, 0);
        open = 0;
      end else if (kind < 92) begin
        send_message($urandom_range(1, PAYLOAD_MAX - 1), 1'($urandom_range(1)), 0, 1);
        open = 1;
      end else begin
        send_message($urandom_range(1, 3), 1'b0, 1, 0);
        open = 0;
      end
    end
    // Close any open message so the phase ends with nothing gathered.
    if (open) offer_byte(8'($urandom_range(255)), 1'b0, 1'b0, 1'b1, NO_PID);
  endtask

  // Receiver: random stalls, or a long hold-off when one is requested.
  always @(posedge clk) begin
    if (hold_trigger != hold_seen) begin
      hold_seen <= hold_trigger;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Compares each accepted packet byte with the oldest prediction.
  always @(posedge clk) begin : check_output
    tx_byte_t want;
    if (!rst && out_valid && out_ready) begin
      bytes_checked++;
      if (end_of_packet) packets_seen++;
      if (tx_bytes_due.size() == 0) begin
        $error("packet byte %02h arrived with no request pending", packet_byte);
        fail_count++;
      end else begin
        want = tx_bytes_due.pop_front();
        if (packet_byte !== want.value) begin
          $error("packet_byte: expected %02h, got %02h", want.value, packet_byte);
          fail_count++;
        end
        if (end_of_packet !== want.eop) begin
          $error("end_of_packet: expected %0b, got %0b", want.eop, end_of_packet);
          fail_count++;
        end
        if (end_of_message !== want.eom) begin
          $error("end_of_message: expected %0b, got %0b", want.eom, end_of_message);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: ends the run when no channel has moved for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Timeout: no handshake for %0d cycles", STALL_LIMIT);
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed rows with reset PID codes and no idling.
    for (int r = 0; r < DIR_ROWS; r++)
      offer_byte(dir_rows[r].value, dir_rows[r].first, dir_rows[r].force_d1,
                 dir_rows[r].last, dir_rows[r].pid);
    settle();

    // Extreme PID codes, sender idling, and a pause until the output drains.
    program_regs(8'h00, 8'hFF, 8'h02, 8'h5A);
    send_idle_pct  = 46;
    recv_stall_pct = 0;
    run_traffic(35, 1);
    settle();

    // Opposite extremes with the receiver stalling.
    program_regs(8'hFF, 8'h00, 8'hFF, 8'hA5);
    send_idle_pct  = 0;
    recv_stall_pct = 46;
    run_traffic(35, 0);
    settle();

    // Random codes with both sides idling.
    program_regs(8'($urandom_range(255)), 8'($urandom_range(255)),
                 CFG_INDEX_W'($urandom_range(2, 254)), 8'($urandom_range(255)));
    send_idle_pct  = 17;
    recv_stall_pct = 17;
    run_traffic(35, 0);
    settle();

    // Reset codes back; a long receiver hold-off fills the block and stalls its input.
    program_regs(PID_DATA0_RESET, PID_DATA1_RESET, 8'h7F, 8'($urandom_range(255)));
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_trigger++;
    run_traffic(25, 0);
    settle();

    $display("Run covered %0d message bytes over directed rows and four random phases,",
             items_sent);
    $display("with PID codes at both extremes; %0d packet bytes in %0d packets checked.",
             bytes_checked, packets_seen);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/udpc_pkg.sv
hdl/udpc_front.sv
hdl/udpc_queue.sv
hdl/udpc_back.sv
hdl/usb_data_packetizer_crc16.sv
hdl/udpc_checker.sv
tb/tb_top.sv
